@@ rtl/fq_pkg.sv @@
// Shared types and constants for the Q24.8 fixed-point ALU.
package fq_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_N_W   = DATA_W + FRAC_BITS;
  localparam int unsigned DIV_STEP  = 2;
  localparam int unsigned DIV_STAGES = (DIV_N_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DIV_W     = DIV_STAGES * DIV_STEP;

  localparam logic signed [DATA_W-1:0] INT_HI = DATA_W'((1 << (31 - FRAC_BITS)) - 1);
  localparam logic signed [DATA_W-1:0] INT_LO = -INT_HI - DATA_W'(1);
  localparam logic [63:0] ROUND_HALF = 64'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_INC      = 4'd6,
    CMD_DEC      = 4'd7,
    CMD_FROM_INT = 4'd8,
    CMD_TO_INT   = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // Per-beat sideband that rides alongside the divider stages.
  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] res;
    status_e           st;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              neg;
  } side_t;

endpackage

@@ rtl/fixed_point_q24_8_alu.sv @@
// Top level of the Q24.8 fixed-point ALU: decode, multiply, divide, round and saturate.
// Every command takes the same path from an accepted start to its result_valid_o strobe.
// Throughput: one command per cycle; busy_o never rises, as nothing downstream can stall.
// That path runs through the divider, twenty stages of two quotient bits each, plus
// a decode stage, a multiply stage, a round stage and an output stage.
// Reset clears every valid bit at once; data registers hold whatever they held.
module fixed_point_q24_8_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [3:0]                command_i,
  input  logic signed [31:0]        operand_a_i,
  input  logic signed [31:0]        operand_b_i,
  output logic                      result_valid_o,
  output logic signed [31:0]        result_value_o,
  output logic                      less_flag_o,
  output logic                      equal_flag_o,
  output logic                      greater_flag_o,
  output logic [1:0]                status_o
);

  localparam int unsigned D = fq_pkg::DATA_W;
  localparam int unsigned W = fq_pkg::DIV_W;
  localparam int unsigned F = fq_pkg::FRAC_BITS;

  // Clamp a sign and magnitude to the signed 32-bit range.
  function automatic logic [D-1:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [D-1:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = 32'h8000_0000;
      else                     r = D'(0) - mag[D-1:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else                     r = mag[D-1:0];
    end
    return r;
  endfunction

  // Clamp a 33-bit signed sum to 32 bits.
  function automatic logic [D-1:0] sat33(input logic [D:0] s);
    logic [D-1:0] r;
    if (s[D] != s[D-1]) r = s[D] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else                r = s[D-1:0];
    return r;
  endfunction

  // The pipeline never stalls, so hold busy low.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------
  // Stage B: decode, compare, simple results, magnitudes.
  // ---------------------------------------------------------------
  fq_pkg::side_t side_b_d, side_b_q;
  logic [D-1:0]  mag_a_d, mag_a_q, mag_b_d, mag_b_q;
  logic          vb_q;

  always_comb begin
    side_b_d     = '0;
    side_b_d.cmd = fq_pkg::cmd_e'(command_i);
    side_b_d.st  = fq_pkg::ST_OK;
    side_b_d.lt  = operand_a_i < operand_b_i;
    side_b_d.eq  = operand_a_i == operand_b_i;
    side_b_d.gt  = operand_a_i > operand_b_i;
    side_b_d.neg = operand_a_i[D-1] ^ operand_b_i[D-1];
    mag_a_d      = operand_a_i[D-1] ? D'(-operand_a_i) : operand_a_i;
    mag_b_d      = operand_b_i[D-1] ? D'(-operand_b_i) : operand_b_i;
    case (fq_pkg::cmd_e'(command_i))
      fq_pkg::CMD_ADD: side_b_d.res = sat33({operand_a_i[D-1], operand_a_i}
                                            + {operand_b_i[D-1], operand_b_i});
      fq_pkg::CMD_SUB: side_b_d.res = sat33({operand_a_i[D-1], operand_a_i}
                                            - {operand_b_i[D-1], operand_b_i});
      fq_pkg::CMD_MUL: side_b_d.res = '0;
      fq_pkg::CMD_DIV: begin
        side_b_d.res = '0;
        if (operand_b_i == '0) side_b_d.st = fq_pkg::ST_DIV_ZERO;
      end
      fq_pkg::CMD_MIN: side_b_d.res = (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i;
      fq_pkg::CMD_MAX: side_b_d.res = (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i;
      fq_pkg::CMD_INC: side_b_d.res = sat33({operand_a_i[D-1], operand_a_i} + (D+1)'(1));
      fq_pkg::CMD_DEC: side_b_d.res = sat33({operand_a_i[D-1], operand_a_i} - (D+1)'(1));
      fq_pkg::CMD_FROM_INT: begin
        if (operand_a_i > fq_pkg::INT_HI || operand_a_i < fq_pkg::INT_LO) begin
          side_b_d.st  = fq_pkg::ST_RANGE;
          side_b_d.res = '0;
        end else begin
          side_b_d.res = operand_a_i << F;
        end
      end
      fq_pkg::CMD_TO_INT: side_b_d.res = D'(operand_a_i >>> F);
      default: side_b_d.res = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Stage C: full product of the magnitudes.
  // ---------------------------------------------------------------
  fq_pkg::side_t side_c_q;
  logic [63:0]   prod_c_q;
  logic [D-1:0]  mag_a_c_q, den_c_q;
  logic          vc_q;

  // ---------------------------------------------------------------
  // Stage D: round and clamp the product; form the dividend.
  // ---------------------------------------------------------------
  fq_pkg::side_t side_d_d, side_d_q;
  logic [63:0]   mul_m;
  logic [W-1:0]  num_d_q;
  logic [D-1:0]  den_d_q;
  logic          vd_q;

  always_comb begin
    side_d_d = side_c_q;
    mul_m    = (prod_c_q + fq_pkg::ROUND_HALF) >> F;
    if (side_c_q.cmd == fq_pkg::CMD_MUL) side_d_d.res = sat_mag(side_c_q.neg, mul_m);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      vb_q <= accept;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_b_q  <= side_b_d;
    mag_a_q   <= mag_a_d;
    mag_b_q   <= mag_b_d;
    side_c_q  <= side_b_q;
    prod_c_q  <= mag_a_q * mag_b_q;
    mag_a_c_q <= mag_a_q;
    den_c_q   <= mag_b_q;
    side_d_q  <= side_d_d;
    num_d_q   <= W'({mag_a_c_q, F'(0)});
    den_d_q   <= den_c_q;
  end

  // ---------------------------------------------------------------
  // Divider: every beat passes through so latency stays uniform.
  // ---------------------------------------------------------------
  logic          div_valid;
  logic [W-1:0]  div_quo;
  logic [D-1:0]  div_rem, div_den;
  fq_pkg::side_t div_side;

  fq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vd_q),
    .num_i   (num_d_q),
    .den_i   (den_d_q),
    .side_i  (side_d_q),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .den_o   (div_den),
    .side_o  (div_side)
  );

  // ---------------------------------------------------------------
  // Stage E: round the quotient half away from zero, clamp, drive the outputs.
  // ---------------------------------------------------------------
  logic [W:0]    div_m;
  logic [D-1:0]  res_e_d, res_e_q;
  fq_pkg::side_t side_e_q;
  logic          ve_q;

  always_comb begin
    div_m   = {1'b0, div_quo} + (W+1)'({div_rem, 1'b0} >= {1'b0, div_den});
    res_e_d = div_side.res;
    if (div_side.cmd == fq_pkg::CMD_DIV && div_side.st == fq_pkg::ST_OK) begin
      res_e_d = sat_mag(div_side.neg, 64'(div_m));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_e_q  <= res_e_d;
    side_e_q <= div_side;
  end

  assign result_valid_o = ve_q;
  assign result_value_o = res_e_q;
  assign less_flag_o    = side_e_q.lt;
  assign equal_flag_o   = side_e_q.eq;
  assign greater_flag_o = side_e_q.gt;
  assign status_o       = side_e_q.st;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $onehot({less_flag_o, equal_flag_o, greater_flag_o}))
    else $error("compare flags not one-hot");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != fq_pkg::ST_OK) |-> result_value_o == '0)
    else $error("error result not zero");

  a_divzero_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == fq_pkg::ST_DIV_ZERO) |-> side_e_q.cmd == fq_pkg::CMD_DIV)
    else $error("divide-by-zero status on a non-divide beat");

endmodule

@@ rtl/fq_div.sv @@
// Pipelined restoring divider, two quotient bits per stage.
module fq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [fq_pkg::DIV_W-1:0]    num_i,
  input  logic [fq_pkg::DATA_W-1:0]   den_i,
  input  fq_pkg::side_t               side_i,
  output logic                        valid_o,
  output logic [fq_pkg::DIV_W-1:0]    quo_o,
  output logic [fq_pkg::DATA_W-1:0]   rem_o,
  output logic [fq_pkg::DATA_W-1:0]   den_o,
  output fq_pkg::side_t               side_o
);

  localparam int unsigned S = fq_pkg::DIV_STAGES;
  localparam int unsigned W = fq_pkg::DIV_W;
  localparam int unsigned D = fq_pkg::DATA_W;

  logic          valid_q [S];
  logic [D-1:0]  rem_q   [S];
  logic [W-1:0]  nq_q    [S];
  logic [D-1:0]  den_q   [S];
  fq_pkg::side_t side_q  [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic          v_in;
    logic [D-1:0]  r_in;
    logic [W-1:0]  nq_in;
    logic [D-1:0]  d_in;
    fq_pkg::side_t sd_in;
    logic [D-1:0]  rem_d;
    logic [W-1:0]  nq_d;
    logic [D:0]    trial;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = '0;
      assign nq_in = num_i;
      assign d_in  = den_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = valid_q[s-1];
      assign r_in  = rem_q[s-1];
      assign nq_in = nq_q[s-1];
      assign d_in  = den_q[s-1];
      assign sd_in = side_q[s-1];
    end

    // Shift in the next numerator bit, subtract where it fits, record the quotient bit.
    always_comb begin
      rem_d = r_in;
      nq_d  = nq_in;
      trial = '0;
      for (int k = 0; k < int'(fq_pkg::DIV_STEP); k++) begin
        trial = {rem_d, nq_d[W-1]};
        nq_d  = {nq_d[W-2:0], 1'b0};
        if (trial >= {1'b0, d_in}) begin
          rem_d   = D'(trial - {1'b0, d_in});
          nq_d[0] = 1'b1;
        end else begin
          rem_d = trial[D-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      nq_q[s]   <= nq_d;
      den_q[s]  <= d_in;
      side_q[s] <= sd_in;
    end
  end

  assign valid_o = valid_q[S-1];
  assign quo_o   = nq_q[S-1];
  assign rem_o   = rem_q[S-1];
  assign den_o   = den_q[S-1];
  assign side_o  = side_q[S-1];

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the Q24.8 fixed-point ALU.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 24;
  localparam int WDOG_MAX  = 2000;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [1:0]  st;
  } alu_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [3:0]         command_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic               result_valid_o;
  logic signed [31:0] result_value_o;
  logic               less_flag_o;
  logic               equal_flag_o;
  logic               greater_flag_o;
  logic [1:0]         status_o;

  alu_cmd_t pending_cmds[$];
  alu_res_t expected_res[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       gap_left = 0;
  bit       hold_off = 1'b0;

  fixed_point_q24_8_alu u_dut (.*);

  always #6 clk_i = ~clk_i;

  // Saturate a signed magnitude to the 32-bit raw range.
  function automatic logic [31:0] clamp_mag(bit neg, logic [63:0] mag);
    if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic logic [31:0] clamp_sum(logic signed [63:0] v);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    return clamp_mag(v[63], mag);
  endfunction

  // Compute the expected beat for one command.
  function automatic alu_res_t alu_predict(alu_cmd_t c);
    alu_res_t r;
    logic signed [63:0] a, b;
    logic [63:0] ma, mb, m, n;
    bit neg;
    a = 64'(c.a);
    b = 64'(c.b);
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    neg = a[63] ^ b[63];
    r = '0;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    r.st = fq_pkg::ST_OK;
    case (c.cmd)
      fq_pkg::CMD_ADD: r.value = clamp_sum(a + b);
      fq_pkg::CMD_SUB: r.value = clamp_sum(a - b);
      fq_pkg::CMD_MUL: begin
        m = (ma * mb + (64'd1 << (fq_pkg::FRAC_BITS - 1))) >> fq_pkg::FRAC_BITS;
        r.value = clamp_mag(neg && m != 0, m);
      end
      fq_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.st = fq_pkg::ST_DIV_ZERO;
        end else begin
          n = ma << fq_pkg::FRAC_BITS;
          m = (2 * n + mb) / (2 * mb);
          r.value = clamp_mag(neg && m != 0, m);
        end
      end
      fq_pkg::CMD_MIN: r.value = (a < b) ? c.a : c.b;
      fq_pkg::CMD_MAX: r.value = (a > b) ? c.a : c.b;
      fq_pkg::CMD_INC: r.value = clamp_sum(a + 1);
      fq_pkg::CMD_DEC: r.value = clamp_sum(a - 1);
      fq_pkg::CMD_FROM_INT: begin
        if (a > 64'(fq_pkg::INT_HI) || a < 64'(fq_pkg::INT_LO)) r.st = fq_pkg::ST_RANGE;
        else r.value = c.a <<< fq_pkg::FRAC_BITS;
      end
      fq_pkg::CMD_TO_INT: r.value = c.a >>> fq_pkg::FRAC_BITS;
      default: r.value = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 600)) - 32'd300;
      3: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      4: return 32'(fq_pkg::INT_HI) + $urandom_range(0, 2) - 1;
      5: return 32'(fq_pkg::INT_LO) + $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    alu_cmd_t c;
    c.cmd = cmd;
    c.a = a;
    c.b = b;
    pending_cmds.push_back(c);
  endtask

  // Driver: present one beat at a time, change inputs on the falling edge.
  always @(negedge clk_i) begin
    alu_cmd_t c;
    if (start_i && !busy_o) begin
      expected_res.push_back(alu_predict(pending_cmds.pop_front()));
      gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) :
                 ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
    end
    if (start_i && busy_o) begin
      // hold the beat until accepted
    end else if (rst_ni && !hold_off && gap_left == 0 && pending_cmds.size() != 0) begin
      c = pending_cmds[0];
      start_i     <= 1'b1;
      command_i   <= c.cmd;
      operand_a_i <= c.a;
      operand_b_i <= c.b;
    end else begin
      start_i <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  // Monitor: compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin
    alu_res_t got, exp_r;
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (result_valid_o) begin
        got = {result_value_o, less_flag_o, equal_flag_o, greater_flag_o, status_o};
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          exp_r = expected_res.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: value exp %h got %h, lt/eq/gt exp %b%b%b got %b%b%b,",
                        " st exp %0d got %0d"},
                       exp_r.value, got.value, exp_r.lt, exp_r.eq, exp_r.gt,
                       got.lt, got.eq, got.gt, exp_r.st, got.st);
          end
        end
      end
      if (idle_cycles >= WDOG_MAX) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    // Directed: extremes, each command and every special case.
    queue_cmd(fq_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1);
    queue_cmd(fq_pkg::CMD_SUB, 32'h8000_0000, 32'd1);
    queue_cmd(fq_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_cmd(fq_pkg::CMD_MUL, 32'd384, -32'sd128);
    queue_cmd(fq_pkg::CMD_MUL, 32'd1, 32'd128);
    queue_cmd(fq_pkg::CMD_DIV, 32'd100, 32'd0);
    queue_cmd(fq_pkg::CMD_DIV, 32'h8000_0000, -32'sd1);
    queue_cmd(fq_pkg::CMD_DIV, -32'sd1, 32'd512);
    queue_cmd(fq_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_cmd(fq_pkg::CMD_MIN, 32'd5, 32'd5);
    queue_cmd(fq_pkg::CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_cmd(fq_pkg::CMD_MAX, 32'd7, 32'd7);
    queue_cmd(fq_pkg::CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_cmd(fq_pkg::CMD_INC, 32'h7FFF_FFFF, 32'd0);
    queue_cmd(fq_pkg::CMD_DEC, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_cmd(fq_pkg::CMD_FROM_INT, fq_pkg::INT_HI, 32'd0);
    queue_cmd(fq_pkg::CMD_FROM_INT, fq_pkg::INT_LO, 32'd0);
    queue_cmd(fq_pkg::CMD_FROM_INT, fq_pkg::INT_HI + 32'd1, 32'd0);
    queue_cmd(fq_pkg::CMD_FROM_INT, fq_pkg::INT_LO - 32'd1, 32'd0);
    queue_cmd(fq_pkg::CMD_TO_INT, -32'sd1, 32'd0);
    queue_cmd(fq_pkg::CMD_TO_INT, 32'h7FFF_FFFF, 32'd0);
    queue_cmd(4'd10, 32'd3, 32'd4);
    queue_cmd(4'd15, 32'hFFFF_FFFF, 32'h0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold the sender off as reset is released, until the first falling clock edge out of reset.
    hold_off = 1'b1;
    @(negedge clk_i);
    hold_off = 1'b0;
    for (int i = 0; i < 600; i++) begin
      queue_cmd(($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9)),
                rand_operand(), ($urandom_range(0, 19) == 0) ? 32'd0 : rand_operand());
      if (i == 300) begin
        // Pause the sender until the pipeline has drained.
        wait (pending_cmds.size() == 0);
        hold_off = 1'b1;
        wait (expected_res.size() == 0);
        @(negedge clk_i);
        hold_off = 1'b0;
      end
    end
    wait (pending_cmds.size() == 0 && !start_i);
    wait (expected_res.size() == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
